@@ hdl/ddwt_pkg.sv @@
// Shared types and constants for the debounced dual-wheel tachometer.
// No dependencies; imported by ddwt_chan and the top level.
package ddwt_pkg;

	// beat kind carried in s_axis_tuser[0]
	typedef enum logic {
		ACT_EDGE   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	// wheel selector carried in s_axis_tuser[1]
	typedef enum logic {
		CH_A = 1'b0,
		CH_B = 1'b1
	} channel_t;

	// per-wheel update strobes from the top level to a channel
	typedef struct packed {
		logic edge_hit;
		logic sample;
	} ddwt_ctl_t;

	localparam int NOW_W   = 32;
	localparam int DEB_W   = 24;
	localparam int SPEED_W = 16;
	localparam int DIST_W  = 32;

	localparam logic [DEB_W-1:0] DEB_RESET = 24'd250;

endpackage

@@ hdl/ddwt_chan.sv @@
// State and update logic for one wheel: pending edge stamp, period count, distance total.
// Depends on ddwt_pkg.
module ddwt_chan
	import ddwt_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddwt_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] thr,
	output logic [SPEED_W-1:0]   speed,
	output logic [DIST_W-1:0]    dist_next
);

	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [TIME_BITS-1:0]  stamp_q, stamp_d;
	logic [DIST_W-1:0]     total_q, total_d;
	logic                  older;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] sat;
	logic [32:0]           sum_ext;
	logic [32:0]           sat_ext;

	// all-ones stamp means no pending edge; it can never be below thr
	assign older   = stamp_q < thr;
	assign sum     = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, older};
	assign sat     = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
	assign sum_ext = 33'(sum);
	assign sat_ext = 33'(sat);
	assign speed   = (|sat_ext[32:SPEED_W]) ? {SPEED_W{1'b1}} : sat_ext[SPEED_W-1:0];
	assign dist_next = total_d;

	always_comb begin
		count_d = count_q;
		stamp_d = stamp_q;
		total_d = total_q;
		if (ctl.edge_hit) begin
			if (older && !(&count_q))
				count_d = count_q + 1'b1;
			stamp_d = now;
		end else if (ctl.sample) begin
			count_d = '0;
			if (older)
				stamp_d = '1;
			total_d = total_q + sum_ext[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stamp_q <= '1;
			total_q <= '0;
		end else begin
			count_q <= count_d;
			stamp_q <= stamp_d;
			total_q <= total_d;
		end
	end

endmodule

@@ hdl/debounced_dual_wheel_tachometer_unit.sv @@
// Top level of the debounced dual-wheel tachometer: input stage, two channels, result register.
// Depends on ddwt_pkg and ddwt_chan.
//
// Use:
//  - Slave stream carries events. tuser[0] is the kind (edge or sample),
//    tuser[1] the wheel of an edge; tdata is the tick time of the event.
//  - An edge beat updates that wheel's pending edge and period count and
//    gives no result. A sample beat closes the period on both wheels and
//    gives one result beat: speeds and wrapping distance totals.
//  - cfg_we/cfg_wdata load the debounce window; write only while idle.
//    The window resets to 250 ticks.
// Timing:
//  - One beat a cycle while the input stage does not stall. A beat is
//    registered in the input stage on acceptance; when it moves on, state
//    updates and a sample beat loads the result register.
//  - The result register parts the sides: while a result waits, edge beats
//    keep flowing; only a sample meeting a full, stalled result register
//    holds the input stage and drops s_axis_tready.
// Reset: clears counts and totals, marks both wheels as having no pending
// edge and empties both the input stage and the result register.
module debounced_dual_wheel_tachometer_unit
	import ddwt_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [DEB_W-1:0]           cfg_wdata,
	// events in
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [NOW_W-1:0]           s_axis_tdata,  // [31:0] now_ticks
	input  logic [1:0]                 s_axis_tuser,  // [0] action, [1] channel
	// results out
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [2*SPEED_W+2*DIST_W-1:0] m_axis_tdata // [15:0] speed_a, [31:16] speed_b,
	                                                   // [63:32] distance_a,
	                                                   // [95:64] distance_b
);

	logic [DEB_W-1:0]     deb_q;

	// input stage
	logic                 valid_s1;
	action_t              action_s1;
	channel_t             channel_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [63:0]          now_wide;

	logic                 advance;
	logic                 in_beat;
	logic [63:0]          thr_wide;
	logic [TIME_BITS-1:0] thr;
	ddwt_ctl_t            ctl_a, ctl_b;
	logic [SPEED_W-1:0]   speed_a, speed_b;
	logic [DIST_W-1:0]    dist_a, dist_b;

	// result register
	logic                 out_valid_q;
	logic [2*SPEED_W+2*DIST_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			deb_q <= DEB_RESET;
		else if (cfg_we)
			deb_q <= cfg_wdata;
	end

	// an edge never needs the result register; a sample needs it free or draining
	assign advance = valid_s1 && (action_s1 == ACT_EDGE || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign now_wide = 64'(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			action_s1  <= action_t'(s_axis_tuser[0]);
			channel_s1 <= channel_t'(s_axis_tuser[1]);
			now_s1     <= now_wide[TIME_BITS-1:0];
		end
	end

	// debounce threshold, wrapping modulo 2^TIME_BITS
	assign thr_wide = 64'(now_s1) - 64'(deb_q);
	assign thr      = thr_wide[TIME_BITS-1:0];

	always_comb begin
		ctl_a.edge_hit = advance && action_s1 == ACT_EDGE && channel_s1 == CH_A;
		ctl_b.edge_hit = advance && action_s1 == ACT_EDGE && channel_s1 == CH_B;
		ctl_a.sample   = advance && action_s1 == ACT_SAMPLE;
		ctl_b.sample   = advance && action_s1 == ACT_SAMPLE;
	end

	ddwt_chan #(
		.TIME_BITS (TIME_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_chan_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_a),
		.now      (now_s1),
		.thr      (thr),
		.speed    (speed_a),
		.dist_next(dist_a)
	);

	ddwt_chan #(
		.TIME_BITS (TIME_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_chan_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_b),
		.now      (now_s1),
		.thr      (thr),
		.speed    (speed_b),
		.dist_next(dist_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl_a.sample)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl_a.sample)
			out_data_q <= {dist_b, dist_a, speed_b, speed_a};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a sample that moves on always lands a result
	a_sample_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == ACT_SAMPLE) |=> m_axis_tvalid)
		else $error("sample beat gave no result");

	// an edge beat never creates a result
	a_edge_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == ACT_EDGE && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("edge beat produced a result");

	// a held input stage is not lost
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1)))
		else $error("stalled input stage dropped");

	// the input stage only stalls on a sample behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (action_s1 == ACT_SAMPLE && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without cause");

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for debounced_dual_wheel_tachometer_unit: directed and random event
// beats, checked against an in-bench tachometer model. Depends on ddwt_pkg and the unit.
`timescale 1ns / 100ps

module tb_top;
	import ddwt_pkg::*;

	localparam int QUIET_LIMIT = 2000; // cycles without any beat before giving up
	localparam int SETTLE      = 4;    // extra wait once every tally is out

	// result beat as it sits on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [DIST_W-1:0]  dist_b;
		logic [DIST_W-1:0]  dist_a;
		logic [SPEED_W-1:0] speed_b;
		logic [SPEED_W-1:0] speed_a;
	} tally_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [DEB_W-1:0]             cfg_wdata = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [NOW_W-1:0]             s_axis_tdata = '0;  // [31:0] now_ticks
	logic [1:0]                   s_axis_tuser = '0;  // [0] action, [1] channel
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [$bits(tally_t)-1:0]    m_axis_tdata;       // speed_a, speed_b, distance_a, distance_b

	debounced_dual_wheel_tachometer_unit dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_wdata,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- tachometer model
	logic [15:0]      pulses [2];      // period count per wheel
	logic [31:0]      last_seen [2];   // pending edge time, all ones = none
	logic [31:0]      dist_total [2];
	logic [DEB_W-1:0] window;
	tally_t           pending[$];      // tallies still to come out

	int errors          = 0;
	int beats_sent      = 0;
	int results_checked = 0;
	int window_writes   = 0;
	bit no_idle         = 1'b0;  // both sides run flat out
	bit hold_valid      = 1'b0;  // tvalid left high for a back-to-back beat
	int gap_next        = 0;
	int sink_stall      = 0;
	int quiet_cycles    = 0;

	// edge is stale once strictly before now - window, modulo 2^32
	function automatic bit is_stale(input logic [31:0] stamp, input logic [31:0] now);
		logic [31:0] threshold;
		threshold = now - {8'd0, window};
		return stamp < threshold;
	endfunction

	task automatic predict_beat(input action_t act, input channel_t ch, input logic [31:0] now);
		logic [16:0] sum [2];
		tally_t      t;
		int          w;
		if (act == ACT_EDGE) begin
			w = ch;
			if (is_stale(last_seen[w], now) && pulses[w] != 16'hFFFF)
				pulses[w]++;
			last_seen[w] = now;
		end else begin
			for (w = 0; w < 2; w++) begin
				sum[w] = {1'b0, pulses[w]};
				if (is_stale(last_seen[w], now)) begin
					sum[w]++;
					last_seen[w] = '1;
				end
				pulses[w] = '0;
				dist_total[w] = dist_total[w] + 32'(sum[w]);  // unsaturated, wraps
			end
			t.speed_a = sum[0][16] ? 16'hFFFF : sum[0][15:0];
			t.speed_b = sum[1][16] ? 16'hFFFF : sum[1][15:0];
			t.dist_a  = dist_total[0];
			t.dist_b  = dist_total[1];
			pending.push_back(t);
		end
	endtask

	// ---------------------------------------------------------------- checking
	task automatic log_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
	endtask

	task automatic check_tally(input tally_t got);
		tally_t want;
		results_checked++;
		if (pending.size() == 0) begin
			log_mismatch("result beat with nothing expected, speed_a", '0, 32'(got.speed_a));
			return;
		end
		want = pending.pop_front();
		if (got.speed_a !== want.speed_a)
			log_mismatch("speed_a", 32'(want.speed_a), 32'(got.speed_a));
		if (got.speed_b !== want.speed_b)
			log_mismatch("speed_b", 32'(want.speed_b), 32'(got.speed_b));
		if (got.dist_a !== want.dist_a)   log_mismatch("distance_a", want.dist_a, got.dist_a);
		if (got.dist_b !== want.dist_b)   log_mismatch("distance_b", want.dist_b, got.dist_b);
	endtask

	// result side: random stall drawn per accepted beat, checked at the same edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_tally(tally_t'(m_axis_tdata));
			sink_stall = no_idle ? 0 : $urandom_range(0, 10);
		end else if (sink_stall > 0) begin
			sink_stall--;
		end
		m_axis_tready <= (sink_stall == 0);
	end

	// watchdog on quiet cycles
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: %0d quiet cycles, %0d tallies outstanding",
				quiet_cycles, pending.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic send_beat(input action_t act, input channel_t ch, input logic [31:0] now);
		if (!hold_valid)
			repeat (gap_next) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= now;
		s_axis_tuser  <= {ch, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_beat(act, ch, now);
		beats_sent++;
		// decide now whether the next beat follows straight on
		gap_next = no_idle ? 0 : $urandom_range(0, 10);
		if (gap_next == 0) begin
			hold_valid = 1'b1;
		end else begin
			s_axis_tvalid <= 1'b0;
			hold_valid = 1'b0;
		end
	endtask

	task automatic edge_beat(input channel_t ch, input logic [31:0] now);
		send_beat(ACT_EDGE, ch, now);
	endtask

	// sample with a random channel bit, which the unit must ignore
	task automatic sample_beat(input logic [31:0] now);
		send_beat(ACT_SAMPLE, channel_t'($urandom_range(0, 1)), now);
	endtask

	// hold the sender until every tally is out and the unit has settled
	task automatic wait_idle();
		if (hold_valid) begin
			s_axis_tvalid <= 1'b0;
			hold_valid = 1'b0;
		end
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_window(input logic [DEB_W-1:0] ticks);
		wait_idle();
		cfg_wdata <= ticks;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		window = ticks;
		window_writes++;
	endtask

	// window left at its reset value of 250 ticks
	task automatic test_reset_window();
		sample_beat(32'd0);                   // nothing pending after reset
		edge_beat(CH_A, 32'd1000);            // first edge: no earlier edge to credit
		edge_beat(CH_A, 32'd1100);            // bounce inside the window
		edge_beat(CH_A, 32'd1351);            // previous just outside: credited
		edge_beat(CH_A, 32'd1601);            // previous exactly on the threshold: not
		sample_beat(32'd1700);                // pending edge still fresh
		sample_beat(32'd2000);                // now stale: credited and cleared
		edge_beat(CH_B, 32'hFFFF_FFFF);       // edge at all ones looks like no edge
		sample_beat(32'd5000);
		edge_beat(CH_B, 32'd6000);
		edge_beat(CH_B, 32'd0);               // wrapped time, threshold wraps too
		edge_beat(CH_A, 32'hFFFF_FE00);
		sample_beat(32'h0000_0050);           // old edge before the wrap still credited
		edge_beat(CH_A, 32'hFFFF_FF80);
		sample_beat(32'h7FFF_FFFF);           // very old edge fails the wrapped compare
		edge_beat(CH_B, 32'h5555_5555);
		edge_beat(CH_B, 32'hAAAA_AAAA);
		sample_beat(32'hFFFF_FFFF);
	endtask

	task automatic test_window_extremes();
		set_window('0);
		sample_beat(32'd400);
		edge_beat(CH_A, 32'd500);
		edge_beat(CH_A, 32'd500);             // same tick: never stale with no window
		edge_beat(CH_A, 32'd501);             // one tick on: credited
		edge_beat(CH_B, 32'd0);
		sample_beat(32'd501);
		set_window('1);
		edge_beat(CH_B, 32'h0000_1000);
		edge_beat(CH_B, 32'h0100_0FFF);       // exactly full window later: not credited
		edge_beat(CH_B, 32'h0200_0FFF);       // one tick more: credited
		sample_beat(32'hFFFF_FFFF);
	endtask

	// flat-out burst of edges at zero window, then samples back to back
	task automatic test_edge_burst();
		int i;
		set_window('0);
		sample_beat(32'd0);
		no_idle = 1'b1;
		for (i = 1; i <= 40; i++) begin
			edge_beat(CH_A, 32'(i));
			if (i % 8 == 0)
				edge_beat(CH_B, 32'(i));
		end
		sample_beat(32'd41);                  // pending edge on top of the count
		sample_beat(32'd42);
		no_idle = 1'b0;
	endtask

	// step to the next event time, spread around the window so compares go both ways
	function automatic logic [31:0] next_step();
		logic [31:0] w;
		w = {8'd0, window};
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1, 2:    return $urandom_range(0, w);
			3:       return w + $urandom_range(0, 1);
			4, 5, 6: return $urandom_range(w, 2 * w + 2);
			7, 8:    return $urandom_range(w + 1, 4 * w + 8);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random(input logic [DEB_W-1:0] ticks, input int items, input bit fast_start);
		logic [31:0] cursor;
		int          i;
		int          pick;
		set_window(ticks);
		// a quarter of the phases start just short of the tick counter wrapping
		cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 3 * {8'd0, ticks} : $urandom;
		for (i = 0; i < items; i++) begin
			no_idle = fast_start && i < 40;
			if ($urandom_range(0, 39) == 0)
				wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_beat(action_t'($urandom_range(0, 1)), channel_t'($urandom_range(0, 1)),
					$urandom);
			end else begin
				cursor += next_step();
				if (pick < 22)
					sample_beat(cursor);
				else
					edge_beat(channel_t'($urandom_range(0, 1)), cursor);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int w;
		for (w = 0; w < 2; w++) begin
			pulses[w]     = '0;
			last_seen[w]  = '1;
			dist_total[w] = '0;
		end
		window = DEB_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_window_extremes();
		test_edge_burst();
		test_random(DEB_W'($urandom_range(1, 2000)), 130, 1'b1);
		test_random('0, 120, 1'b0);
		test_random('1, 120, 1'b0);
		test_random(DEB_RESET, 130, 1'b0);
		test_random(DEB_W'($urandom_range(0, 24'hFFFFFF)), 120, 1'b0);

		wait_idle();
		repeat (2 * SETTLE) @(posedge clk);
		$display("Run covered %0d event beats and %0d tally beats over %0d window settings,",
			beats_sent, results_checked, window_writes);
		$display("incl. zero and full-scale windows, tick wrap and flat-out edge bursts.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
